[hw/rtl/smc_pkg.sv]
// smc_pkg: shared widths, limits and register indexes for the substring
// match counter. No dependencies.
`timescale 1ns / 1ps

package smc_pkg;

  // longest string position that is reported; start positions saturate here
  localparam int unsigned MAX_LENGTH = 65535;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned NBYTES_W   = 64;
  localparam int unsigned NLEN_W     = 4;
  localparam int unsigned COUNT_W    = 17;
  localparam int unsigned INDEX_W    = 16;
  localparam int unsigned IN_TDATA_W = 8;
  localparam int unsigned OUT_TDATA_W = 56;
  localparam int unsigned CFG_IDX_W  = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NEEDLE_BYTES  = 1'b0,
    REG_NEEDLE_LENGTH = 1'b1
  } cfg_reg_t;

endpackage

[hw/rtl/substring_match_counter_top.sv]
// substring_match_counter_top: streams haystack bytes against a configured
// needle and reports matches, count and first/last start positions.
// Depends on smc_pkg.
`timescale 1ns / 1ps

// channel  | dir | beat contents
// ---------+-----+------------------------------------------------------------
// in_      | in  | tdata: data_byte; tuser: has_byte; tlast: end_of_string
// out_     | out | tdata: match flags, count, found, first/last; tlast: final_res
// cfg_     | in  | single-cycle register write, index 0 needle bytes, 1 length
//
// One beat per cycle sustained while the output is not stalled; a beat's result
// passes through the input register, then the result register, to the output. All
// per-string state is updated as a beat moves from the input register to the
// result register, so consecutive beats see each other's effects with no bubble.
// A stalled output holds the result register and backs up into the input register;
// reset is synchronous and clears the needle to length one and all string state.

module substring_match_counter_top #(
  parameter int unsigned MAX_NEEDLE = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [smc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [smc_pkg::NBYTES_W-1:0]        cfg_wdata,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [smc_pkg::IN_TDATA_W-1:0]      in_tdata,   // [7:0] data_byte
  input  logic                                in_tuser,   // has_byte
  input  logic                                in_tlast,   // end_of_string
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] here flag, [1] counted flag, [18:2] count, [19] found,
  // [35:20] first_index, [51:36] last_index, [55:52] zero
  output logic [smc_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                out_tlast   // final_res
);

  localparam int unsigned WIN_D = (MAX_NEEDLE > 1) ? MAX_NEEDLE - 1 : 1;
  localparam int unsigned POS_W = $clog2(smc_pkg::MAX_LENGTH + MAX_NEEDLE + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(smc_pkg::MAX_LENGTH + MAX_NEEDLE);
  localparam logic [POS_W-1:0] POS_LIM = POS_W'(smc_pkg::MAX_LENGTH);
  localparam logic [smc_pkg::COUNT_W-1:0] CNT_MAX =
    smc_pkg::COUNT_W'(smc_pkg::MAX_LENGTH + 1);
  localparam logic [smc_pkg::NLEN_W-1:0] LEN_MAX = smc_pkg::NLEN_W'(MAX_NEEDLE);

  // configuration registers
  logic [smc_pkg::NBYTES_W-1:0] needle_r;
  logic [smc_pkg::NLEN_W-1:0]   nlen_r;

  // input register
  logic                         s1_valid_r;
  logic [smc_pkg::BYTE_W-1:0]   s1_byte_r;
  logic                         s1_has_r;
  logic                         s1_last_r;

  // per-string state
  logic [smc_pkg::BYTE_W-1:0]   win_r [WIN_D];
  logic [POS_W-1:0]             pos_r;
  logic [smc_pkg::COUNT_W-1:0]  cnt_r;
  logic [smc_pkg::INDEX_W-1:0]  first_r;
  logic [smc_pkg::INDEX_W-1:0]  last_r;
  logic                         found_r;
  logic [smc_pkg::NLEN_W-1:0]   ovl_r;

  // result register
  logic                           out_valid_r;
  logic [smc_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic                           out_last_r;

  logic adv1;
  logic item_go;

  assign adv1      = !out_valid_r || out_tready;
  assign item_go   = s1_valid_r && adv1;
  assign in_tready = !s1_valid_r || adv1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // match datapath
  logic [smc_pkg::NLEN_W-1:0]   len_c;
  logic [smc_pkg::BYTE_W-1:0]   hay_c [MAX_NEEDLE];
  logic                         cmp_ok;
  logic                         here_c;
  logic                         counted_c;
  logic [POS_W-1:0]             start_c;
  logic [smc_pkg::INDEX_W-1:0]  start_sat_c;
  logic [POS_W-1:0]             pos_nxt;
  logic [smc_pkg::COUNT_W-1:0]  cnt_nxt;
  logic [smc_pkg::INDEX_W-1:0]  first_nxt;
  logic [smc_pkg::INDEX_W-1:0]  last_nxt;
  logic                         found_nxt;
  logic [smc_pkg::NLEN_W-1:0]   ovl_nxt;
  logic [smc_pkg::INDEX_W-1:0]  seen_c;
  logic [smc_pkg::COUNT_W-1:0]  count_out_c;
  logic                         found_out_c;
  logic [smc_pkg::INDEX_W-1:0]  first_out_c;
  logic [smc_pkg::INDEX_W-1:0]  last_out_c;

  assign len_c = (nlen_r > LEN_MAX) ? LEN_MAX : nlen_r;

  always_comb begin
    hay_c[0] = s1_byte_r;
    for (int k = 1; k < MAX_NEEDLE; k++) begin
      hay_c[k] = win_r[k-1];
    end
  end

  // byte k back from the current one faces needle byte len-1-k
  always_comb begin
    logic [2:0] nidx;
    cmp_ok = 1'b1;
    for (int k = 0; k < MAX_NEEDLE; k++) begin
      nidx = 3'(len_c - smc_pkg::NLEN_W'(k) - smc_pkg::NLEN_W'(1));
      if (smc_pkg::NLEN_W'(k) < len_c &&
          hay_c[k] != needle_r[{nidx, 3'b000} +: smc_pkg::BYTE_W]) begin
        cmp_ok = 1'b0;
      end
    end
  end

  assign here_c = s1_has_r && (len_c != '0) &&
                  ({1'b0, pos_r} + (POS_W+1)'(1) >= (POS_W+1)'(len_c)) && cmp_ok;

  assign start_c     = pos_r - POS_W'(len_c - smc_pkg::NLEN_W'(1));
  assign start_sat_c = (start_c > POS_LIM) ? smc_pkg::INDEX_W'(smc_pkg::MAX_LENGTH)
                                           : start_c[smc_pkg::INDEX_W-1:0];

  always_comb begin
    counted_c = 1'b0;
    cnt_nxt   = cnt_r;
    ovl_nxt   = ovl_r;
    first_nxt = first_r;
    last_nxt  = last_r;
    found_nxt = found_r;
    pos_nxt   = pos_r;
    if (s1_has_r) begin
      if (here_c) begin
        if (!found_r) begin
          first_nxt = start_sat_c;
        end
        last_nxt  = start_sat_c;
        found_nxt = 1'b1;
      end
      // greedy non-overlap: skip matches that end inside the last counted one
      if (ovl_r != '0) begin
        ovl_nxt = ovl_r - smc_pkg::NLEN_W'(1);
      end else if (here_c) begin
        counted_c = 1'b1;
        if (cnt_r < CNT_MAX) begin
          cnt_nxt = cnt_r + smc_pkg::COUNT_W'(1);
        end
        ovl_nxt = len_c - smc_pkg::NLEN_W'(1);
      end
      if (pos_r < POS_MAX) begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  // empty needle matches everywhere, including past the end
  assign seen_c = (pos_nxt > POS_LIM) ? smc_pkg::INDEX_W'(smc_pkg::MAX_LENGTH)
                                      : pos_nxt[smc_pkg::INDEX_W-1:0];

  always_comb begin
    if (len_c == '0) begin
      count_out_c = smc_pkg::COUNT_W'(seen_c) + smc_pkg::COUNT_W'(1);
      found_out_c = 1'b1;
      first_out_c = '0;
      last_out_c  = seen_c;
    end else begin
      count_out_c = cnt_nxt;
      found_out_c = found_nxt;
      first_out_c = first_nxt;
      last_out_c  = last_nxt;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needle_r <= '0;
      nlen_r   <= smc_pkg::NLEN_W'(1);
    end else if (cfg_we) begin
      unique case (smc_pkg::cfg_reg_t'(cfg_index))
        smc_pkg::REG_NEEDLE_BYTES:  needle_r <= cfg_wdata;
        smc_pkg::REG_NEEDLE_LENGTH: nlen_r   <= cfg_wdata[smc_pkg::NLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata[smc_pkg::BYTE_W-1:0];
      s1_has_r  <= in_tuser;
      s1_last_r <= in_tlast;
    end
  end

  // string state, cleared after the last beat of a string
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WIN_D; i++) begin
        win_r[i] <= '0;
      end
      pos_r   <= '0;
      cnt_r   <= '0;
      first_r <= '0;
      last_r  <= '0;
      found_r <= 1'b0;
      ovl_r   <= '0;
    end else if (item_go) begin
      if (s1_last_r) begin
        for (int i = 0; i < WIN_D; i++) begin
          win_r[i] <= '0;
        end
        pos_r   <= '0;
        cnt_r   <= '0;
        first_r <= '0;
        last_r  <= '0;
        found_r <= 1'b0;
        ovl_r   <= '0;
      end else begin
        if (s1_has_r) begin
          win_r[0] <= s1_byte_r;
          for (int i = 1; i < WIN_D; i++) begin
            win_r[i] <= win_r[i-1];
          end
        end
        pos_r   <= pos_nxt;
        cnt_r   <= cnt_nxt;
        first_r <= first_nxt;
        last_r  <= last_nxt;
        found_r <= found_nxt;
        ovl_r   <= ovl_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv1) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (item_go) begin
      out_data_r <= {4'b0000, last_out_c, first_out_c, found_out_c, count_out_c,
                     counted_c, here_c};
      out_last_r <= s1_last_r;
    end
  end

`ifndef ASSERT_OFF
  // a counted match is always a match
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] || !out_tdata[1]))
    else $error("counted flag without match");

  // the overlap span never exceeds the needle
  assert property (@(posedge clk) disable iff (!rst_n)
    ovl_r <= LEN_MAX)
    else $error("overlap span out of range");

  // a finished string leaves clean state behind
  assert property (@(posedge clk) disable iff (!rst_n)
    (item_go && s1_last_r) |=> (pos_r == '0 && cnt_r == '0 && !found_r))
    else $error("string state not cleared");

  // state moves only with a beat
  assert property (@(posedge clk) disable iff (!rst_n)
    !item_go |=> ($stable(pos_r) && $stable(cnt_r) && $stable(ovl_r)))
    else $error("string state changed without a beat");
`endif

endmodule

[sim/tb.sv]
// tb: self-checking bench for substring_match_counter_top, streaming haystack
// beats against several needles and checking every result beat in order.
// Depends on smc_pkg and the substring_match_counter_top RTL.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned NEEDLE_MAX  = 8;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned MAX_SHOWN   = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       eos;
  } hay_beat_t;

  typedef struct packed {
    logic        here;
    logic        counted;
    logic [16:0] count;
    logic        found;
    logic [15:0] first_idx;
    logic [15:0] last_idx;
    logic        final_res;
  } scan_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [smc_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [smc_pkg::NBYTES_W-1:0]    cfg_wdata = '0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [smc_pkg::IN_TDATA_W-1:0]  in_tdata = '0;   // [7:0] data_byte
  logic                            in_tuser = 1'b0; // has_byte
  logic                            in_tlast = 1'b0; // end_of_string
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [smc_pkg::OUT_TDATA_W-1:0] out_tdata;       // [0] here, [1] counted, [18:2] count,
                                                    // [19] found, [35:20] first, [51:36] last
  logic                            out_tlast;       // final_res

  substring_match_counter_top #(.MAX_NEEDLE(NEEDLE_MAX)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  hay_beat_t    haystack_q[$];
  scan_result_t scan_expect_q[$];
  hay_beat_t    beat_on_bus;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;
  int unsigned  beats_queued = 0;
  int unsigned  beats_in = 0;
  int unsigned  results_out = 0;
  int unsigned  strings_sent = 0;
  int unsigned  counted_seen = 0;
  int unsigned  mismatches = 0;
  int unsigned  quiet_cycles = 0;

  // scanner copy: needle config plus per-string state
  logic [63:0]  needle_val;
  logic [3:0]   needle_len_val;
  logic [7:0]   recent_bytes [NEEDLE_MAX-1];
  int unsigned  bytes_seen;
  int unsigned  counted_total;
  int unsigned  first_start;
  int unsigned  last_start;
  bit           seen_any;
  int unsigned  cover_left;

  function automatic void forget_string();
    foreach (recent_bytes[i]) recent_bytes[i] = 8'h00;
    bytes_seen    = 0;
    counted_total = 0;
    first_start   = 0;
    last_start    = 0;
    seen_any      = 1'b0;
    cover_left    = 0;
  endfunction

  function automatic int unsigned needle_span();
    return (needle_len_val > NEEDLE_MAX) ? NEEDLE_MAX : needle_len_val;
  endfunction

  function automatic scan_result_t scan_byte(hay_beat_t b);
    scan_result_t r;
    int unsigned  len, start, seen, k;
    logic [7:0]   hay;
    bit           here, counted;
    len     = needle_span();
    here    = 1'b0;
    counted = 1'b0;
    if (b.has_byte) begin
      if (len > 0 && bytes_seen + 1 >= len) begin
        here = 1'b1;
        for (k = 0; k < len; k++) begin
          hay = (k == 0) ? b.data : recent_bytes[k-1];
          if (hay != needle_val[8*(len-1-k) +: 8]) here = 1'b0;
        end
      end
      if (here) begin
        start = bytes_seen - (len - 1);
        if (start > smc_pkg::MAX_LENGTH) start = smc_pkg::MAX_LENGTH;
        if (!seen_any) first_start = start;
        last_start = start;
        seen_any   = 1'b1;
      end
      // greedy non-overlap: bytes of a counted occurrence block new counts
      if (cover_left > 0) begin
        cover_left--;
      end else if (here) begin
        counted = 1'b1;
        if (counted_total < smc_pkg::MAX_LENGTH + 1) counted_total++;
        cover_left = len - 1;
      end
      for (k = NEEDLE_MAX - 2; k > 0; k--) recent_bytes[k] = recent_bytes[k-1];
      recent_bytes[0] = b.data;
      if (bytes_seen < smc_pkg::MAX_LENGTH + NEEDLE_MAX) bytes_seen++;
    end
    r.here      = here;
    r.counted   = counted;
    r.final_res = b.eos;
    if (len == 0) begin
      seen        = (bytes_seen > smc_pkg::MAX_LENGTH) ? smc_pkg::MAX_LENGTH : bytes_seen;
      r.count     = 17'(seen + 1);
      r.found     = 1'b1;
      r.first_idx = '0;
      r.last_idx  = 16'(seen);
    end else begin
      r.count     = 17'(counted_total);
      r.found     = seen_any;
      r.first_idx = 16'(first_start);
      r.last_idx  = 16'(last_start);
    end
    if (b.eos) forget_string();
    return r;
  endfunction

  // driver: one new beat whenever the bus is free, random sender gaps
  always @(posedge clk) begin : p_drive
    hay_beat_t nb;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= 1'b0;
      in_tlast  <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        scan_expect_q.push_back(scan_byte(beat_on_bus));
        beats_in++;
      end
      if (!in_tvalid || in_tready) begin
        if (haystack_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nb          = haystack_q.pop_front();
          beat_on_bus = nb;
          in_tvalid   <= 1'b1;
          in_tdata    <= nb.data;
          in_tuser    <= nb.has_byte;
          in_tlast    <= nb.eos;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result beat with the oldest prediction
  always @(posedge clk) begin : p_check
    scan_result_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.here      = out_tdata[0];
        got.counted   = out_tdata[1];
        got.count     = out_tdata[18:2];
        got.found     = out_tdata[19];
        got.first_idx = out_tdata[35:20];
        got.last_idx  = out_tdata[51:36];
        got.final_res = out_tlast;
        results_out++;
        if (got.counted === 1'b1) counted_seen++;
        if (scan_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("[%0t] unexpected result beat %h last=%b", $realtime, out_tdata,
                     out_tlast);
        end else begin
          want = scan_expect_q.pop_front();
          if (got.here !== want.here || got.counted !== want.counted ||
              got.count !== want.count || got.found !== want.found ||
              got.first_idx !== want.first_idx || got.last_idx !== want.last_idx ||
              got.final_res !== want.final_res) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
              $display({"[%0t] result %0d: exp here=%b cnt'd=%b count=%0d found=%b ",
                        "first=%0d last=%0d fin=%b, got %b %b %0d %b %0d %0d %b"},
                       $realtime, results_out - 1, want.here, want.counted, want.count,
                       want.found, want.first_idx, want.last_idx, want.final_res,
                       got.here, got.counted, got.count, got.found, got.first_idx,
                       got.last_idx, got.final_res);
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles, %0d results outstanding",
               quiet_cycles, scan_expect_q.size());
      $display("substring_match_counter_top: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_beat(logic [7:0] data, logic has_byte, logic eos);
    hay_beat_t b;
    b.data     = data;
    b.has_byte = has_byte;
    b.eos      = eos;
    haystack_q.push_back(b);
    beats_queued++;
    if (eos) strings_sent++;
  endtask

  task automatic push_text(string s, logic eos);
    for (int i = 0; i < s.len(); i++) push_beat(s[i], 1'b1, eos && (i == s.len() - 1));
  endtask

  // every queued beat accepted and every result taken
  task automatic wait_drained();
    while (beats_in != beats_queued || results_out < beats_queued)
      @(posedge clk);
  endtask

  // only called with nothing in flight, so the scanner copy follows at once
  task automatic write_reg(smc_pkg::cfg_reg_t idx, logic [63:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx == smc_pkg::REG_NEEDLE_BYTES) needle_val = value;
    else needle_len_val = value[3:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] pick_byte(int unsigned len);
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 2) return 8'($urandom);
    if (len == 0) return needle_val[8*$urandom_range(7) +: 8];
    return needle_val[8*$urandom_range(len - 1) +: 8];
  endfunction

  // mostly needle copies and needle bytes so matches and overlaps are common
  task automatic push_random_string(int unsigned n);
    int unsigned i, k, len;
    len = needle_span();
    i   = 0;
    while (i < n) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          for (k = 0; k < ((len == 0) ? 1 : len) && i < n; k++) begin
            push_beat(needle_val[8*k +: 8], 1'b1, 1'b0);
            i++;
          end
        end
        3: begin
          push_beat(8'($urandom), 1'b0, 1'b0);
          i++;
        end
        default: begin
          push_beat(pick_byte(len), 1'b1, 1'b0);
          i++;
        end
      endcase
    end
    push_beat(pick_byte(len), ($urandom_range(3) != 0), 1'b1);
  endtask

  function automatic logic [63:0] random_needle(int unsigned flavor);
    logic [63:0] v;
    v = {$urandom, $urandom};
    case (flavor)
      0: for (int j = 0; j < 8; j++) v[8*j +: 8] = $urandom_range(1) ? 8'h41 : 8'h42;
      1: ;
      default: for (int j = 0; j < 8; j++) v[8*j +: 8] = $urandom_range(1) ? 8'h00 : 8'hFF;
    endcase
    return v;
  endfunction

  initial begin
    int unsigned lens [12] = '{1, 2, 3, 8, 0, 4, 15, 5, 7, 6, 2, 8};
    int unsigned round_goal;
    needle_val     = '0;
    needle_len_val = 4'd1;
    forget_string();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 14;
    recv_idle_pct = 51;
    // reset needle is one zero byte
    push_beat(8'h00, 1'b1, 1'b0);
    push_beat(8'hFF, 1'b1, 1'b0);
    push_beat(8'h00, 1'b1, 1'b1);
    push_beat(8'h00, 1'b0, 1'b1);
    wait_drained();
    // overlapping occurrences, only every other one counted, byte-less beat inside
    write_reg(smc_pkg::REG_NEEDLE_BYTES, 64'h6161);
    write_reg(smc_pkg::REG_NEEDLE_LENGTH, 64'd2);
    push_text("aa", 1'b0);
    push_beat(8'h5A, 1'b0, 1'b0);
    push_text("aa", 1'b1);
    wait_drained();
    // empty needle, then the empty string
    write_reg(smc_pkg::REG_NEEDLE_LENGTH, 64'd0);
    push_text("xy", 1'b1);
    push_beat(8'hFF, 1'b0, 1'b1);
    wait_drained();
    // length above the maximum saturates to a full eight-byte needle
    write_reg(smc_pkg::REG_NEEDLE_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(smc_pkg::REG_NEEDLE_LENGTH, 64'd15);
    for (int i = 0; i < 9; i++) push_beat(8'hFF, 1'b1, (i == 8));
    wait_drained();
    // needle shortened in the middle of a string
    write_reg(smc_pkg::REG_NEEDLE_BYTES, 64'h636261);
    write_reg(smc_pkg::REG_NEEDLE_LENGTH, 64'd3);
    push_text("ab", 1'b0);
    wait_drained();
    write_reg(smc_pkg::REG_NEEDLE_LENGTH, 64'd2);
    push_text("cab", 1'b1);
    wait_drained();

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 14 : (mode == 1) ? 51 : 0;
      recv_idle_pct = (mode == 0) ? 51 : (mode == 1) ? 14 : 0;
      for (int r = 0; r < 4; r++) begin
        write_reg(smc_pkg::REG_NEEDLE_BYTES, random_needle($urandom_range(2)));
        write_reg(smc_pkg::REG_NEEDLE_LENGTH, 64'(lens[mode*4 + r]));
        round_goal = beats_queued + 140;
        while (beats_queued < round_goal) begin
          push_random_string(($urandom_range(9) == 0) ? $urandom_range(60) :
                             $urandom_range(20));
          // hold the sender once until the pipeline has emptied
          if (mode == 0 && r == 1 && beats_queued + 75 >= round_goal &&
              beats_queued + 50 < round_goal)
            wait_drained();
        end
        wait_drained();
      end
    end

    // the needle goes empty with a string still open
    write_reg(smc_pkg::REG_NEEDLE_BYTES, 64'h61);
    write_reg(smc_pkg::REG_NEEDLE_LENGTH, 64'd1);
    for (int i = 0; i < 12; i++) push_beat(8'h61, 1'b1, 1'b0);
    wait_drained();
    write_reg(smc_pkg::REG_NEEDLE_LENGTH, 64'd0);
    push_text("ab", 1'b0);
    push_beat(8'h00, 1'b0, 1'b1);
    wait_drained();

    repeat (8) @(posedge clk);
    $display("sent %0d beats in %0d strings, checked %0d results (%0d counted matches)",
             beats_in, strings_sent, results_out, counted_seen);
    $display("needle lengths 0..15 incl. saturation, empty strings, mid-string reconfig");
    if (mismatches == 0 && scan_expect_q.size() == 0) begin
      $display("substring_match_counter_top: match");
    end else begin
      $display("%0d bad result beats, %0d results missing", mismatches,
               scan_expect_q.size());
      $display("substring_match_counter_top: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/smc_pkg.sv
hw/rtl/substring_match_counter_top.sv
sim/tb.sv
